// ===== rtl/pbr_pkg.sv =====
`default_nettype none

package pbr_pkg;

  localparam int MAX_DIM_DEF = 63;
  localparam int COORD_W     = 8;
  localparam int DIM_W       = 6;
  localparam int SYM_W       = 8;
  localparam int ERR_W       = 12;
  localparam int ROW_W       = 10;

  localparam logic [DIM_W-1:0] GRID_RESET = 6'd63;

  typedef enum logic {
    CFG_GRID_WIDTH  = 1'b0,
    CFG_GRID_HEIGHT = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MARK,
    ST_LINE
  } state_t;

  typedef struct packed {
    logic load;
    logic emit_marker;
    logic emit_line;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic draw;
    logic line_final;
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/pbr_if.sv =====
`default_nettype none

interface pbr_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [pbr_pkg::COORD_W-1:0]  x_pos;
  logic signed [pbr_pkg::COORD_W-1:0]  y_pos;
  logic        [pbr_pkg::SYM_W-1:0]    symbol;
  logic                                line_mode;
  logic                                first_of_series;

  modport source (output valid, x_pos, y_pos, symbol, line_mode, first_of_series,
                  input ready);
  modport sink (input valid, x_pos, y_pos, symbol, line_mode, first_of_series,
                output ready);
endinterface

interface pbr_out_if;
  logic                          valid;
  logic                          ready;
  logic [pbr_pkg::DIM_W-1:0]     cell_row;
  logic [pbr_pkg::DIM_W-1:0]     cell_col;
  logic [pbr_pkg::SYM_W-1:0]     cell_symbol;
  logic                          visible;
  logic                          last;

  modport source (output valid, cell_row, cell_col, cell_symbol, visible, last,
                  input ready);
  modport sink (input valid, cell_row, cell_col, cell_symbol, visible, last,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/pbr_ctrl.sv =====
`default_nettype none

module pbr_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire pbr_pkg::status_t status,
  output pbr_pkg::cmd_t         cmd
);

  pbr_pkg::state_t state_r;
  pbr_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pbr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pbr_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = pbr_pkg::ST_MARK;
      end
      pbr_pkg::ST_MARK: begin
        if (status.out_free) state_nxt = status.draw ? pbr_pkg::ST_LINE : pbr_pkg::ST_IDLE;
      end
      pbr_pkg::ST_LINE: begin
        if (status.out_free && status.line_final) state_nxt = pbr_pkg::ST_IDLE;
      end
      default: state_nxt = pbr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready         = 1'b0;
    cmd.load         = 1'b0;
    cmd.emit_marker  = 1'b0;
    cmd.emit_line    = 1'b0;
    case (state_r)
      pbr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      pbr_pkg::ST_MARK: cmd.emit_marker = status.out_free;
      pbr_pkg::ST_LINE: cmd.emit_line   = status.out_free;
      default: in_ready = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/pbr_datapath.sv =====
`default_nettype none

module pbr_datapath #(
  parameter int MAX_DIM = pbr_pkg::MAX_DIM_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic signed [pbr_pkg::COORD_W-1:0]  in_x,
  input  wire logic signed [pbr_pkg::COORD_W-1:0]  in_y,
  input  wire logic        [pbr_pkg::SYM_W-1:0]    in_symbol,
  input  wire logic                                in_draw,
  input  wire logic        [pbr_pkg::DIM_W-1:0]    grid_width,
  input  wire logic        [pbr_pkg::DIM_W-1:0]    grid_height,
  input  wire pbr_pkg::cmd_t                       cmd,
  output pbr_pkg::status_t                         status,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic             [pbr_pkg::DIM_W-1:0]    out_row,
  output logic             [pbr_pkg::DIM_W-1:0]    out_col,
  output logic             [pbr_pkg::SYM_W-1:0]    out_symbol,
  output logic                                     out_visible,
  output logic                                     out_last
);

  localparam int CW = $clog2(MAX_DIM + 1);
  localparam int XW = pbr_pkg::COORD_W;
  localparam int EW = pbr_pkg::ERR_W;
  localparam int RW = pbr_pkg::ROW_W;

  logic signed [XW-1:0]          prev_x_r, prev_y_r;
  logic signed [XW-1:0]          x1_r, y1_r, cx_r, cy_r;
  logic        [pbr_pkg::SYM_W-1:0] sym_r;
  logic                          draw_r, sx_neg_r, sy_neg_r;
  logic signed [EW-1:0]          dx_r, dy_r, err_r;
  logic        [CW-1:0]          cnt_r;

  logic                          out_valid_r;
  logic        [pbr_pkg::DIM_W-1:0] row_r, col_r;
  logic        [pbr_pkg::SYM_W-1:0] osym_r;
  logic                          vis_r, last_r;

  logic signed [EW-1:0]          ddx, ddy, adx, ady, e2, err_nxt;
  logic                          at_end, step_x, step_y, emit;
  logic signed [XW-1:0]          px, py;
  logic signed [RW-1:0]          row;
  logic                          vis, last;

  // Load-time deltas from the previous point
  always_comb begin
    ddx = EW'(in_x) - EW'(prev_x_r);
    ddy = EW'(in_y) - EW'(prev_y_r);
    adx = ddx[EW-1] ? -ddx : ddx;
    ady = ddy[EW-1] ? -ddy : ddy;
  end

  always_comb begin
    e2      = err_r <<< 1;
    step_x  = e2 >= dy_r;
    step_y  = e2 <= dx_r;
    err_nxt = err_r + (step_x ? dy_r : '0) + (step_y ? dx_r : '0);
    at_end  = (cx_r == x1_r) && (cy_r == y1_r);
  end

  assign status.out_free   = !out_valid_r || out_ready;
  assign status.draw       = draw_r;
  assign status.line_final = at_end || (cnt_r == CW'(MAX_DIM - 1));

  // Cell placement and clipping
  always_comb begin
    px   = cmd.emit_marker ? x1_r : cx_r;
    py   = cmd.emit_marker ? y1_r : cy_r;
    row  = RW'(grid_height) - RW'(1) - RW'(py);
    vis  = !px[XW-1] && ({1'b0, px[XW-2:0]} < XW'(grid_width)) &&
           !row[RW-1] && (row < RW'(grid_height));
    last = cmd.emit_marker ? !draw_r : status.line_final;
    emit = cmd.emit_marker || cmd.emit_line;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        prev_x_r <= in_x;
        prev_y_r <= in_y;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x1_r     <= in_x;
      y1_r     <= in_y;
      sym_r    <= in_symbol;
      draw_r   <= in_draw;
      cx_r     <= prev_x_r;
      cy_r     <= prev_y_r;
      sx_neg_r <= !(prev_x_r < in_x);
      sy_neg_r <= !(prev_y_r < in_y);
      dx_r     <= adx;
      dy_r     <= -ady;
      err_r    <= adx - ady;
      cnt_r    <= '0;
    end else if (cmd.emit_line) begin
      if (step_x) cx_r <= sx_neg_r ? cx_r - XW'(1) : cx_r + XW'(1);
      if (step_y) cy_r <= sy_neg_r ? cy_r - XW'(1) : cy_r + XW'(1);
      err_r <= err_nxt;
      cnt_r <= cnt_r + CW'(1);
    end
    if (emit) begin
      row_r  <= vis ? row[pbr_pkg::DIM_W-1:0] : '0;
      col_r  <= vis ? px[pbr_pkg::DIM_W-1:0] : '0;
      osym_r <= sym_r;
      vis_r  <= vis;
      last_r <= last;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_row     = row_r;
  assign out_col     = col_r;
  assign out_symbol  = osym_r;
  assign out_visible = vis_r;
  assign out_last    = last_r;

endmodule

`default_nettype wire

// ===== rtl/polyline_bresenham_rasterizer.sv =====
// Polyline rasterizer with Bresenham line drawing.
// in_chan: one grid point per transaction (x_pos, y_pos, symbol, line_mode,
//   first_of_series). out_chan: one cell per transaction, with last set on
//   the final cell of each point.
// cfg_*: cfg_we writes cfg_data into grid_width (index 0) or grid_height
//   (index 1); write only while the block is idle.
// Each point yields a marker cell; with line_mode set and first_of_series
//   clear it then yields the line cells from the previous point, endpoints
//   included, at most MAX_DIM of them.
// Flow: the point is taken in the idle state, then the single Bresenham
//   step unit emits one cell per cycle while the output register is free
//   (empty, or out_chan.ready high); each cell is registered before it shows.
//   The next point is taken only after the point's last cell is emitted.
// The output register holds a cell while out_chan.ready is low; the line
//   walk pauses until it is taken.
// Reset: synchronous, active low; grid size returns to 63x63 and the
//   previous point to (0,0). No clearing pass.
`default_nettype none

module polyline_bresenham_rasterizer #(
  parameter int MAX_DIM = pbr_pkg::MAX_DIM_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  pbr_in_if.sink                           in_chan,
  pbr_out_if.source                        out_chan,
  input  wire logic                        cfg_we,
  input  wire logic                        cfg_index,
  input  wire logic [pbr_pkg::DIM_W-1:0]   cfg_data
);

  logic [pbr_pkg::DIM_W-1:0] grid_width_r, grid_height_r;
  pbr_pkg::cmd_t             cmd;
  pbr_pkg::status_t          status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= pbr_pkg::GRID_RESET;
      grid_height_r <= pbr_pkg::GRID_RESET;
    end else if (cfg_we) begin
      case (pbr_pkg::cfg_idx_t'(cfg_index))
        pbr_pkg::CFG_GRID_WIDTH:  grid_width_r  <= cfg_data;
        pbr_pkg::CFG_GRID_HEIGHT: grid_height_r <= cfg_data;
        default: grid_width_r <= grid_width_r;
      endcase
    end
  end

  pbr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .status   (status),
    .cmd      (cmd)
  );

  pbr_datapath #(
    .MAX_DIM (MAX_DIM)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_x        (in_chan.x_pos),
    .in_y        (in_chan.y_pos),
    .in_symbol   (in_chan.symbol),
    .in_draw     (in_chan.line_mode && !in_chan.first_of_series),
    .grid_width  (grid_width_r),
    .grid_height (grid_height_r),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (out_chan.valid),
    .out_ready   (out_chan.ready),
    .out_row     (out_chan.cell_row),
    .out_col     (out_chan.cell_col),
    .out_symbol  (out_chan.cell_symbol),
    .out_visible (out_chan.visible),
    .out_last    (out_chan.last)
  );

endmodule

`default_nettype wire

// ===== rtl/pbr_checker.sv =====
`default_nettype none

module pbr_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [pbr_pkg::DIM_W-1:0]   out_row,
  input wire logic [pbr_pkg::DIM_W-1:0]   out_col,
  input wire logic [pbr_pkg::SYM_W-1:0]   out_symbol,
  input wire logic                        out_visible,
  input wire logic                        out_last
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_one_point: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second point taken before the first was drawn");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input open while a point still has cells to deliver");

  a_clip_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_visible |-> out_row == '0 && out_col == '0)
    else $error("clipped cell carries a position");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_row) && $stable(out_col) &&
      $stable(out_symbol) && $stable(out_visible) && $stable(out_last))
    else $error("stalled cell changed");

endmodule

bind polyline_bresenham_rasterizer pbr_checker u_pbr_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_chan.valid),
  .in_ready    (in_chan.ready),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .out_row     (out_chan.cell_row),
  .out_col     (out_chan.cell_col),
  .out_symbol  (out_chan.cell_symbol),
  .out_visible (out_chan.visible),
  .out_last    (out_chan.last)
);

`default_nettype wire
